FILE: sv/rolling_hash_substring_query_top_assert.svh
// Assertion macros for the rolling hash block checker
`ifndef ROLLING_HASH_SUBSTRING_QUERY_TOP_ASSERT_SVH
`define ROLLING_HASH_SUBSTRING_QUERY_TOP_ASSERT_SVH

// Same-cycle property, sampled on clk, quiet while rst_n is low
`define RHSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define RHSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rhsq_pkg.sv
package rhsq_pkg;

    localparam int HASH_W     = 61;
    localparam int BASE_W     = 31;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 12;
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam int MAX_LEN_DEF = 4095;

    localparam logic [HASH_W-1:0] HASH_MOD   = {HASH_W{1'b1}};
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(131);

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] result;
    } mul_rsp_t;

    // Bring a value below twice the modulus into [0, P)
    function automatic logic [HASH_W-1:0] mod_reduce(input logic [HASH_W:0] s);
        logic [HASH_W:0] diff;
        diff = s - {1'b0, HASH_MOD};
        if (s >= {1'b0, HASH_MOD})
        begin
            return diff[HASH_W-1:0];
        end
        return s[HASH_W-1:0];
    endfunction

endpackage

FILE: sv/rhsq_ram.sv
module rhsq_ram #(
    parameter int WIDTH = rhsq_pkg::HASH_W,
    parameter int DEPTH = rhsq_pkg::MAX_LEN_DEF + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/rhsq_mulmod.sv
module rhsq_mulmod (
    input  logic               clk,
    input  logic               rst_n,
    input  rhsq_pkg::mul_req_t req,
    output rhsq_pkg::mul_rsp_t rsp
);

    localparam int HW = rhsq_pkg::HASH_W;
    localparam int LW = rhsq_pkg::BASE_W;

    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;
    localparam logic [1:0] PP_HH = 2'd3;

    localparam logic [2:0] CNT_FIRST_ACC = 3'd1;
    localparam logic [2:0] CNT_LAST_ACC  = 3'd4;
    localparam logic [2:0] CNT_FOLD      = 3'd5;

    logic              busy_reg;
    logic [2:0]        cnt_reg;
    logic              done_reg;
    logic [HW-1:0]     a_reg;
    logic [HW-1:0]     b_reg;
    logic [2*LW-1:0]   prod_reg;
    logic [1:0]        kind_reg;
    logic [63:0]       acc_reg;
    logic [HW-1:0]     res_reg;

    logic [LW-1:0]     op_x;
    logic [LW-1:0]     op_y;
    logic [2*LW-1:0]   prod_next;
    logic [63:0]       term;
    logic [HW:0]       fold_sum;

    assign op_x      = cnt_reg[1] ? {1'b0, a_reg[HW-1:LW]} : a_reg[LW-1:0];
    assign op_y      = cnt_reg[0] ? {1'b0, b_reg[HW-1:LW]} : b_reg[LW-1:0];
    assign prod_next = op_x * op_y;

    // 2^61 = 1 mod P: a cross term x * 2^31 folds to (x >> 30) + ((x & M30) << 31)
    always_comb
    begin
        unique case (kind_reg)
            PP_LL:        term = {2'b0, prod_reg};
            PP_LH, PP_HL: term = {3'b0, prod_reg[29:0], prod_reg[60:30]};
            PP_HH:        term = {2'b0, prod_reg[60:0], 1'b0};
            default:      term = '0;
        endcase
    end

    assign fold_sum = {1'b0, acc_reg[HW-1:0]} + (HW+1)'(acc_reg[63:HW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_FOLD);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_FOLD)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_next;
            kind_reg <= cnt_reg[1:0];
            if (cnt_reg == CNT_FIRST_ACC)
            begin
                acc_reg <= term;
            end
            else if ((cnt_reg > CNT_FIRST_ACC) && (cnt_reg <= CNT_LAST_ACC))
            begin
                acc_reg <= acc_reg + term;
            end
            if (cnt_reg == CNT_FOLD)
            begin
                res_reg <= rhsq_pkg::mod_reduce(fold_sum);
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

FILE: sv/rolling_hash_substring_query_top.sv
// Channel   Direction  tdata                                     tuser
// s_axis    in         char_value, left_index, right_index       operation
// m_axis    out        hash_value (61 bits, zero padded to 64)   index_error
// cfg       in         hash_base (31 bits), write on cfg_wr_en   -
//
// Append and query items run from acceptance to the next acceptance through S_READ,
// S_READ2, S_START, S_MUL and S_OUT: the product passes four times through the 31 x 31
// multiplier in rhsq_mulmod, after synchronous reads of the prefix and power memories.
// Clear, unused codes and rejected items go from S_IDLE straight to S_OUT.
// Reset is asynchronous; memories need no clearing pass, entry 0 reads as 0 and 1.
// A finished item waits in the output register while the next item is taken.
module rolling_hash_substring_query_top #(
    parameter int MAX_LEN = rhsq_pkg::MAX_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rhsq_pkg::BASE_W-1:0]         cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] char_value, [19:8] left_index, [31:20] right_index
    input  logic [rhsq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] operation
    input  logic [rhsq_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [60:0] hash_value, [63:61] zero
    output logic [rhsq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] index_error
    output logic [0:0]                          m_axis_tuser
);

    localparam int HW    = rhsq_pkg::HASH_W;
    localparam int IW    = rhsq_pkg::IDX_W;
    localparam int DEPTH = MAX_LEN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > IW) ? AW : IW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_READ2,
        S_START,
        S_MUL,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [AW-1:0]                   len_reg;
    logic [rhsq_pkg::BASE_W-1:0]     base_reg;
    logic [rhsq_pkg::OP_W-1:0]       op_reg;
    logic [rhsq_pkg::CHAR_W-1:0]     c_reg;
    logic [IW-1:0]                   l_reg;
    logic [IW-1:0]                   r_reg;
    logic                            zp_reg;
    logic                            zw_reg;
    logic [HW-1:0]                   pa_reg;
    logic [HW-1:0]                   pw_reg;
    logic [HW-1:0]                   hr_reg;
    logic [HW-1:0]                   res_hash_reg;
    logic                            res_err_reg;
    logic                            m_valid_reg;
    logic [HW-1:0]                   m_hash_reg;
    logic                            m_err_reg;

    logic [rhsq_pkg::CHAR_W-1:0]     in_char;
    logic [IW-1:0]                   in_left;
    logic [IW-1:0]                   in_right;
    logic                            accept;
    logic                            full;
    logic                            bad_range;
    logic [IW-1:0]                   span;

    logic                            p_re;
    logic [AW-1:0]                   p_raddr;
    logic [HW-1:0]                   p_rdata;
    logic                            w_re;
    logic [AW-1:0]                   w_raddr;
    logic [HW-1:0]                   w_rdata;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;

    rhsq_pkg::mul_req_t              req0;
    rhsq_pkg::mul_req_t              req1;
    rhsq_pkg::mul_rsp_t              rsp0;
    rhsq_pkg::mul_rsp_t              rsp1;

    logic [HW-1:0]                   hv_append;
    logic [HW-1:0]                   hv_query;

    assign in_char  = s_axis_tdata[7:0];
    assign in_left  = s_axis_tdata[19:8];
    assign in_right = s_axis_tdata[31:20];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full      = (len_reg >= AW'(MAX_LEN));
    assign bad_range = (in_left > in_right) || (CW'(in_right) > CW'(len_reg));
    assign span      = r_reg - l_reg;

    always_comb
    begin
        p_re    = 1'b0;
        w_re    = 1'b0;
        p_raddr = len_reg;
        w_raddr = len_reg;
        unique case (state_reg)
            S_READ:
            begin
                p_re = 1'b1;
                w_re = 1'b1;
                if (op_reg == rhsq_pkg::OP_QUERY)
                begin
                    p_raddr = AW'(l_reg);
                    w_raddr = AW'(span);
                end
            end
            S_READ2:
            begin
                p_re    = (op_reg == rhsq_pkg::OP_QUERY);
                p_raddr = AW'(r_reg);
            end
            default:
            begin
                p_re = 1'b0;
            end
        endcase
    end

    assign hv_append = rhsq_pkg::mod_reduce({1'b0, rsp0.result} + (HW+1)'(c_reg));
    assign hv_query  = rhsq_pkg::mod_reduce({1'b0, hr_reg} + {1'b0, rhsq_pkg::HASH_MOD}
                                            - {1'b0, rsp0.result});

    assign mem_we    = (state_reg == S_MUL) && rsp0.done && (op_reg == rhsq_pkg::OP_APPEND);
    assign mem_waddr = len_reg + AW'(1);

    assign req0.start = (state_reg == S_START);
    assign req0.a     = pa_reg;
    assign req0.b     = (op_reg == rhsq_pkg::OP_APPEND) ? HW'(base_reg) : pw_reg;
    assign req1.start = (state_reg == S_START) && (op_reg == rhsq_pkg::OP_APPEND);
    assign req1.a     = pw_reg;
    assign req1.b     = HW'(base_reg);

    rhsq_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (hv_append),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rhsq_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_power_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (rsp1.result),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    rhsq_mulmod u_mul_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req0),
        .rsp   (rsp0)
    );

    rhsq_mulmod u_mul_power (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req1),
        .rsp   (rsp1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            base_reg     <= rhsq_pkg::BASE_RESET;
            op_reg       <= '0;
            c_reg        <= '0;
            l_reg        <= '0;
            r_reg        <= '0;
            zp_reg       <= 1'b0;
            zw_reg       <= 1'b0;
            pa_reg       <= '0;
            pw_reg       <= '0;
            hr_reg       <= '0;
            res_hash_reg <= '0;
            res_err_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_hash_reg   <= '0;
            m_err_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            if (m_axis_tready && (state_reg != S_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= s_axis_tuser;
                        c_reg        <= in_char;
                        l_reg        <= in_left;
                        r_reg        <= in_right;
                        res_hash_reg <= '0;
                        unique case (s_axis_tuser)
                            rhsq_pkg::OP_APPEND:
                            begin
                                res_err_reg <= full;
                                state_reg   <= full ? S_OUT : S_READ;
                            end
                            rhsq_pkg::OP_QUERY:
                            begin
                                res_err_reg <= bad_range;
                                state_reg   <= bad_range ? S_OUT : S_READ;
                            end
                            rhsq_pkg::OP_CLEAR:
                            begin
                                len_reg     <= '0;
                                res_err_reg <= 1'b0;
                                state_reg   <= S_OUT;
                            end
                            default:
                            begin
                                res_err_reg <= 1'b0;
                                state_reg   <= S_OUT;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    if (op_reg == rhsq_pkg::OP_QUERY)
                    begin
                        zp_reg <= (l_reg == '0);
                        zw_reg <= (span == '0);
                    end
                    else
                    begin
                        zp_reg <= (len_reg == '0);
                        zw_reg <= (len_reg == '0);
                    end
                    state_reg <= S_READ2;
                end
                S_READ2:
                begin
                    // entry 0 of both stores is fixed: hash 0, power 1
                    pa_reg    <= zp_reg ? '0 : p_rdata;
                    pw_reg    <= zw_reg ? HW'(1) : w_rdata;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    hr_reg    <= (r_reg == '0) ? '0 : p_rdata;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (rsp0.done)
                    begin
                        if (op_reg == rhsq_pkg::OP_APPEND)
                        begin
                            res_hash_reg <= hv_append;
                            len_reg      <= len_reg + AW'(1);
                        end
                        else
                        begin
                            res_hash_reg <= hv_query;
                        end
                        res_err_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_hash_reg  <= res_hash_reg;
                        m_err_reg   <= res_err_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(rhsq_pkg::OUT_DATA_W - HW){1'b0}}, m_hash_reg};
    assign m_axis_tuser  = m_err_reg;

endmodule

FILE: sv/rhsq_checker.sv
`include "rolling_hash_substring_query_top_assert.svh"

module rhsq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_wr_en,
    input logic [rhsq_pkg::BASE_W-1:0]         cfg_wr_data,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [rhsq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input logic [rhsq_pkg::OP_W-1:0]           s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [rhsq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic [0:0]                          m_axis_tuser
);

    localparam logic [rhsq_pkg::OUT_DATA_W-1:0] MOD_WIDE =
        rhsq_pkg::OUT_DATA_W'(rhsq_pkg::HASH_MOD);

    logic                              err_item;
    logic                              in_take;
    logic                              out_stall;
    logic [rhsq_pkg::OUT_DATA_W:0]     out_word;

    assign err_item  = m_axis_tvalid && m_axis_tuser[0];
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `RHSQ_ASSERT(a_err_zero_hash, !err_item || (m_axis_tdata == '0), "error item, hash nonzero")

    `RHSQ_ASSERT(a_hash_reduced, !m_axis_tvalid || (m_axis_tdata < MOD_WIDE), "hash not reduced")

    `RHSQ_ASSERT_NEXT(a_one_at_a_time, in_take, !s_axis_tready, "item taken while busy")

    `RHSQ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "held item changed")

endmodule

bind rolling_hash_substring_query_top rhsq_checker u_rhsq_checker (.*);
